/* hw/rtl/rlt_pkg.sv */
// Shared types and constants for the resource lease table.
// Holds the transaction structs, command and status codes and register indexes.
// No dependencies.
package rlt_pkg;

    localparam int NUM_RESOURCES_DEF = 16;
    localparam int TIME_BITS_DEF     = 48;
    localparam int NUM_USERS         = 16;

    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 5;
    localparam int NEFF_W     = 6;

    localparam logic [1:0] FUNC_RESERVE   = 2'd0;
    localparam logic [1:0] FUNC_SWEEP     = 2'd1;
    localparam logic [1:0] FUNC_FREE_USER = 2'd2;
    localparam logic [1:0] FUNC_FREE_ALL  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_NO_ACCESS = 2'd2;
    localparam logic [1:0] ST_BUSY      = 2'd3;

    localparam logic REG_RESOURCE_COUNT  = 1'b0;
    localparam logic REG_USER_ALLOW_MASK = 1'b1;

    localparam logic KIND_DONE   = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  user_id;
        logic [3:0]  res_index;
        logic [31:0] lease_ms;
        logic [47:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [3:0] rel_index;
        logic [3:0] rel_user;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic       req;
        logic [3:0] user;
    } notice_t;

endpackage

/* hw/rtl/rlt_cell.sv */
// One table entry of the resource lease table with its slot of the token chain.
// Uses rlt_pkg for the command struct, codes and notice struct.
module rlt_cell #(
    parameter int IDX       = 0,
    parameter int TIME_BITS = rlt_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  rlt_pkg::cmd_t               cmd,
    input  logic [TIME_BITS-1:0]        now,
    input  logic [rlt_pkg::NEFF_W-1:0]  n_eff,
    input  logic                        tok_in,
    input  logic [1:0]                  st_in,
    output logic                        tok_out,
    output logic [1:0]                  st_out,
    output rlt_pkg::notice_t            notice
);

    logic                 tok_reg;
    logic [1:0]           st_reg;
    logic                 busy_reg;
    logic [3:0]           owner_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic [31:0]          life_reg;

    logic [TIME_BITS:0]   lease_end;
    logic                 live;
    logic                 in_use;
    logic                 hit;
    logic                 own;
    logic                 renew;
    logic                 grant;
    logic                 release_now;

    assign lease_end = {1'b0, start_reg} + (TIME_BITS + 1)'(life_reg);
    assign live      = lease_end >= {1'b0, now};
    assign in_use    = rlt_pkg::NEFF_W'(IDX) < n_eff;
    assign hit       = rlt_pkg::NEFF_W'(IDX) == {2'b00, cmd.res_index};
    assign own       = busy_reg && (owner_reg == cmd.user_id);

    always_comb
    begin
        renew       = 1'b0;
        grant       = 1'b0;
        release_now = 1'b0;
        st_out      = st_reg;
        case (cmd.func)
            rlt_pkg::FUNC_RESERVE:
            begin
                if (hit && st_reg == rlt_pkg::ST_OK)
                begin
                    if (own)
                        renew = 1'b1;
                    else if (busy_reg && live)
                        st_out = rlt_pkg::ST_BUSY;
                    else
                        grant = 1'b1;
                end
            end
            rlt_pkg::FUNC_SWEEP:     release_now = in_use && busy_reg && !live;
            rlt_pkg::FUNC_FREE_USER: release_now = in_use && own;
            default:                 release_now = 1'b0;
        endcase
    end

    assign tok_out     = tok_reg;
    assign notice.req  = tok_reg && release_now;
    assign notice.user = owner_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= 1'b0;
            busy_reg <= 1'b0;
        end
        else if (advance)
        begin
            tok_reg <= tok_in;
            if (tok_reg && (release_now || cmd.func == rlt_pkg::FUNC_FREE_ALL))
                busy_reg <= 1'b0;
            else if (tok_reg && grant)
                busy_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg <= st_in;
            if (tok_reg && (renew || grant))
                start_reg <= now;
            if (tok_reg && grant)
            begin
                owner_reg <= cmd.user_id;
                life_reg  <= cmd.lease_ms;
            end
        end
    end

endmodule

/* hw/rtl/resource_lease_table.sv */
// Top level of the resource lease table: command intake, config registers,
// chain of rlt_cell entries and the response register. Uses rlt_pkg.
//
//   port group         direction  handshake                 content
//   cmd                in         cmd_valid / cmd_stall     rlt_pkg::cmd_t
//   rsp                out        rsp_valid / rsp_stall     rlt_pkg::rsp_t
//   cfg                in         cfg_wr (no wait)          cfg_addr, cfg_wdata
//
// Without stalls, a token walks the cell chain one entry per cycle, then the
// completion transaction is loaded.
// A stalled response holds the chain only while a cell has a notice to send.
// Reset clears every busy flag and loads the config defaults; no clearing pass.
module resource_lease_table #(
    parameter int NUM_RESOURCES = rlt_pkg::NUM_RESOURCES_DEF,
    parameter int TIME_BITS     = rlt_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  rlt_pkg::cmd_t                   cmd,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output rlt_pkg::rsp_t                   rsp,
    input  logic                            cfg_wr,
    input  logic                            cfg_addr,
    input  logic [rlt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [rlt_pkg::COUNT_W-1:0] count_reg;
    logic [15:0]                 mask_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [1:0]                  fin_st_reg;
    rlt_pkg::cmd_t               cmd_reg;
    logic                        rsp_valid_reg;
    rlt_pkg::rsp_t               rsp_reg;

    logic [rlt_pkg::NEFF_W-1:0]  n_eff;
    logic [TIME_BITS-1:0]        now;
    logic                        accept;
    logic [1:0]                  pre_st;
    logic                        advance;
    logic                        out_free;
    logic                        need;
    rlt_pkg::rsp_t               notice_rsp;

    logic [NUM_RESOURCES:0]      tok;
    logic [1:0]                  st [NUM_RESOURCES+1];
    rlt_pkg::notice_t            notice [NUM_RESOURCES];

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign advance   = !(need && !out_free);
    assign now       = TIME_BITS'(cmd_reg.now_ms);

    assign n_eff = ({1'b0, count_reg} > rlt_pkg::NEFF_W'(NUM_RESOURCES))
                 ? rlt_pkg::NEFF_W'(NUM_RESOURCES) : {1'b0, count_reg};

    always_comb
    begin
        pre_st = rlt_pkg::ST_OK;
        if (cmd.func == rlt_pkg::FUNC_RESERVE)
        begin
            if ({2'b00, cmd.res_index} >= n_eff)
                pre_st = rlt_pkg::ST_BAD_INDEX;
            else if (32'(cmd.user_id) >= rlt_pkg::NUM_USERS || !mask_reg[cmd.user_id])
                pre_st = rlt_pkg::ST_NO_ACCESS;
        end
    end

    assign tok[0] = accept;
    assign st[0]  = pre_st;

    for (genvar i = 0; i < NUM_RESOURCES; i++)
    begin : g_cell
        rlt_cell #(
            .IDX       (i),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .cmd     (cmd_reg),
            .now     (now),
            .n_eff   (n_eff),
            .tok_in  (tok[i]),
            .st_in   (st[i]),
            .tok_out (tok[i+1]),
            .st_out  (st[i+1]),
            .notice  (notice[i])
        );
    end

    always_comb
    begin
        need       = 1'b0;
        notice_rsp = '0;
        for (int i = 0; i < NUM_RESOURCES; i++)
        begin
            if (notice[i].req)
            begin
                need                 = 1'b1;
                notice_rsp.rel_index = 4'(i);
                notice_rsp.rel_user  = notice[i].user;
            end
        end
        notice_rsp.kind   = rlt_pkg::KIND_NOTICE;
        notice_rsp.status = rlt_pkg::ST_OK;
        notice_rsp.last   = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= rlt_pkg::COUNT_W'(16);
            mask_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                rlt_pkg::REG_RESOURCE_COUNT:  count_reg <= cfg_wdata[rlt_pkg::COUNT_W-1:0];
                rlt_pkg::REG_USER_ALLOW_MASK: mask_reg  <= cfg_wdata[15:0];
                default:                      mask_reg  <= mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (done_reg && out_free)
                busy_reg <= 1'b0;

            if (tok[NUM_RESOURCES] && advance)
                done_reg <= 1'b1;
            else if (done_reg && out_free)
                done_reg <= 1'b0;

            if (need && advance)
                rsp_valid_reg <= 1'b1;
            else if (done_reg && out_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
        if (tok[NUM_RESOURCES] && advance)
            fin_st_reg <= st[NUM_RESOURCES];
        if (need && advance)
            rsp_reg <= notice_rsp;
        else if (done_reg && out_free)
        begin
            rsp_reg.kind      <= rlt_pkg::KIND_DONE;
            rsp_reg.status    <= fin_st_reg;
            rsp_reg.rel_index <= '0;
            rsp_reg.rel_user  <= '0;
            rsp_reg.last      <= 1'b1;
        end
    end

endmodule

/* tb/resource_lease_table_tb.sv */
// Self-checking testbench for resource_lease_table: directed table, then random phases.
// Predicts every response from its own copy of the lease table and registers; directed rows may type the status.
// Depends on rlt_pkg and resource_lease_table.
`timescale 1ns / 1ps

module resource_lease_table_tb;
    import rlt_pkg::*;

    localparam int N_RES          = NUM_RESOURCES_DEF;
    localparam int RAND_PER_PHASE = 59;
    localparam int N_PHASES       = 8;
    localparam int LONG_HOLD      = 400;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PREDICTED      = -1;

    typedef struct {
        bit                    is_cfg;
        int                    typed_st;
        cmd_t                  c;
        logic                  cfg_addr;
        logic [CFG_DATA_W-1:0] cfg_data;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_t                  cmd = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_wr = 1'b0;
    logic                  cfg_addr = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predicted table contents and registers
    bit           lease_busy [N_RES];
    logic [3:0]   lease_owner[N_RES];
    logic [47:0]  lease_start[N_RES];
    logic [31:0]  lease_life [N_RES];
    logic [4:0]   count_reg;
    logic [15:0]  allow_reg;
    logic [47:0]  wall_ms;

    rsp_t     due_rsp[$];
    dir_row_t dir_rows[$];

    int  errors = 0;
    int  cycles = 0;
    int  n_cmd = 0;
    int  n_rsp = 0;
    int  n_notice = 0;
    int  n_cfg = 0;
    bit  long_hold_req = 1'b0;

    resource_lease_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wr    (cfg_wr),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, due_rsp.size());
            $display("resource_lease_table_tb: done, errors");
            $finish;
        end
    end

    task automatic report(input string msg);
        if (errors < 50)
            $display("[%0t] MISMATCH %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got,
                               input logic [3:0] want);
        if (got !== want)
            report($sformatf("response %0d: %s got %0d want %0d", n_rsp, name, got, want));
    endtask

    function automatic void queue_rsp(input rsp_t r);
        due_rsp.insert(due_rsp.size(), r);
    endfunction

    function automatic void add_row(input dir_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void drop_entry(input int e);
        lease_busy[e]  = 1'b0;
        lease_owner[e] = '0;
        lease_start[e] = '0;
        lease_life[e]  = '0;
    endfunction

    function automatic bit lease_live(input int e, input logic [47:0] now);
        logic [48:0] expiry;
        expiry = {1'b0, lease_start[e]} + {17'd0, lease_life[e]};
        return expiry >= {1'b0, now};
    endfunction

    // Work out the responses of one command and update the table.
    task automatic table_step(input cmd_t c, input int typed_st);
        rsp_t       r;
        int         n;
        int         e;
        logic [1:0] st;
        n = (count_reg > N_RES) ? N_RES : int'(count_reg);
        st = ST_OK;
        e = int'(c.res_index);
        case (c.func)
            FUNC_RESERVE:
            begin
                if (e >= n)
                    st = ST_BAD_INDEX;
                else if (!allow_reg[c.user_id])
                    st = ST_NO_ACCESS;
                else if (lease_busy[e] && lease_owner[e] == c.user_id)
                    lease_start[e] = c.now_ms;
                else if (lease_busy[e] && lease_live(e, c.now_ms))
                    st = ST_BUSY;
                else
                begin
                    lease_busy[e]  = 1'b1;
                    lease_owner[e] = c.user_id;
                    lease_start[e] = c.now_ms;
                    lease_life[e]  = c.lease_ms;
                end
            end
            FUNC_SWEEP, FUNC_FREE_USER:
            begin
                for (int k = 0; k < n; k++)
                begin
                    if (lease_busy[k] && ((c.func == FUNC_SWEEP) ? !lease_live(k, c.now_ms)
                                          : (lease_owner[k] == c.user_id)))
                    begin
                        r = '{kind: KIND_NOTICE, status: ST_OK, rel_index: 4'(k),
                              rel_user: lease_owner[k], last: 1'b0};
                        queue_rsp(r);
                        drop_entry(k);
                    end
                end
            end
            default:
            begin
                for (int k = 0; k < N_RES; k++)
                    drop_entry(k);
            end
        endcase
        if (typed_st >= 0)
            st = 2'(typed_st);
        r = '{kind: KIND_DONE, status: st, rel_index: 4'd0, rel_user: 4'd0, last: 1'b1};
        queue_rsp(r);
    endtask

    task automatic send_cmd(input cmd_t c, input int typed_st);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (cmd_stall);
        table_step(c, typed_st);
        n_cmd++;
    endtask

    task automatic idle_sender(input int n);
        repeat (n)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
    endtask

    task automatic drain_table();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (due_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [CFG_DATA_W-1:0] data);
        drain_table();
        cfg_wr <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr <= 1'b0;
        if (addr == REG_RESOURCE_COUNT)
            count_reg = data[COUNT_W-1:0];
        else
            allow_reg = data;
        n_cfg++;
    endtask

    function automatic dir_row_t cmd_row(input logic [1:0] f, input logic [3:0] u,
                                         input logic [3:0] idx, input logic [31:0] lease,
                                         input logic [47:0] now, input int typed_st);
        dir_row_t row;
        row.is_cfg   = 1'b0;
        row.typed_st = typed_st;
        row.c        = '{func: f, user_id: u, res_index: idx, lease_ms: lease, now_ms: now};
        row.cfg_addr = 1'b0;
        row.cfg_data = '0;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic addr, input logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row.is_cfg   = 1'b1;
        row.typed_st = PREDICTED;
        row.c        = '0;
        row.cfg_addr = addr;
        row.cfg_data = data;
        return row;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   r;
        r = $urandom_range(0, 99);
        c.func = (r < 62) ? FUNC_RESERVE : (r < 82) ? FUNC_SWEEP
               : (r < 96) ? FUNC_FREE_USER : FUNC_FREE_ALL;
        c.user_id = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        c.res_index = 4'($urandom);
        r = $urandom_range(0, 15);
        c.lease_ms = (r < 12) ? 32'($urandom_range(0, 40)) : (r < 14) ? $urandom
                   : (r == 14) ? 32'd0 : 32'hFFFF_FFFF;
        wall_ms = wall_ms + 48'($urandom_range(0, 6));
        c.now_ms = ($urandom_range(0, 15) == 0) ? 48'({$urandom, $urandom}) : wall_ms;
        return c;
    endfunction

    always @(posedge clk)
    begin
        rsp_t w;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_rsp.size() == 0)
                report($sformatf("unexpected response %p", rsp));
            else
            begin
                w = due_rsp.pop_front();
                check_field("kind", 4'(rsp.kind), 4'(w.kind));
                check_field("status", 4'(rsp.status), 4'(w.status));
                check_field("rel_index", rsp.rel_index, w.rel_index);
                check_field("rel_user", rsp.rel_user, w.rel_user);
                check_field("last", 4'(rsp.last), 4'(w.last));
                if (w.kind == KIND_NOTICE)
                    n_notice++;
            end
            n_rsp++;
        end
    end

    initial
    begin : rsp_pacer
        int mode;
        int ticks;
        mode = 0;
        ticks = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                if (ticks == 0)
                begin
                    mode = $urandom_range(0, 3);
                    ticks = $urandom_range(20, 120);
                end
                ticks--;
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= ($urandom_range(0, 9) < 7);
                    default: rsp_stall <= (ticks % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [4:0]  cnt;
        logic [15:0] mask;
        int          burst_left;

        for (int k = 0; k < N_RES; k++)
            drop_entry(k);
        count_reg = 5'd16;
        allow_reg = '0;
        wall_ms = 48'({$urandom, $urandom});

        add_row(cmd_row(FUNC_RESERVE, 0, 0, 10, 0, ST_NO_ACCESS));
        add_row(cmd_row(FUNC_RESERVE, 15, 15, 10, 0, ST_NO_ACCESS));
        add_row(cfg_row(REG_USER_ALLOW_MASK, 16'hFFFF));
        add_row(cmd_row(FUNC_RESERVE, 15, 15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                        ST_OK));
        add_row(cmd_row(FUNC_RESERVE, 0, 15, 0, 0, ST_BUSY));
        add_row(cmd_row(FUNC_RESERVE, 0, 0, 0, 100, ST_OK));
        add_row(cmd_row(FUNC_RESERVE, 1, 0, 5, 100, ST_BUSY));
        add_row(cmd_row(FUNC_RESERVE, 1, 0, 5, 101, ST_OK));
        add_row(cmd_row(FUNC_RESERVE, 1, 0, 9, 200, ST_OK));
        add_row(cmd_row(FUNC_SWEEP, 0, 0, 0, 205, PREDICTED));
        add_row(cmd_row(FUNC_SWEEP, 0, 0, 0, 206, PREDICTED));
        add_row(cmd_row(FUNC_RESERVE, 3, 1, 10, 300, ST_OK));
        add_row(cmd_row(FUNC_RESERVE, 3, 2, 10, 300, ST_OK));
        add_row(cmd_row(FUNC_FREE_USER, 3, 0, 0, 310, PREDICTED));
        add_row(cmd_row(FUNC_FREE_USER, 9, 0, 0, 320, ST_OK));
        add_row(cfg_row(REG_RESOURCE_COUNT, 16'd0));
        add_row(cmd_row(FUNC_RESERVE, 0, 0, 1, 400, ST_BAD_INDEX));
        add_row(cfg_row(REG_RESOURCE_COUNT, 16'd31));
        add_row(cmd_row(FUNC_RESERVE, 2, 15, 1, 500, ST_BUSY));
        add_row(cfg_row(REG_RESOURCE_COUNT, 16'd4));
        add_row(cmd_row(FUNC_RESERVE, 2, 4, 1, 600, ST_BAD_INDEX));
        add_row(cmd_row(FUNC_RESERVE, 2, 3, 0, 1000, ST_OK));
        add_row(cmd_row(FUNC_SWEEP, 0, 0, 0, 48'hFFFF_FFFF_FFFF, PREDICTED));
        add_row(cmd_row(FUNC_FREE_USER, 15, 0, 0, 1100, ST_OK));
        add_row(cfg_row(REG_USER_ALLOW_MASK, 16'h0001));
        add_row(cmd_row(FUNC_RESERVE, 1, 0, 3, 1200, ST_NO_ACCESS));
        add_row(cfg_row(REG_RESOURCE_COUNT, 16'd16));
        add_row(cmd_row(FUNC_FREE_USER, 15, 0, 0, 1300, PREDICTED));
        add_row(cmd_row(FUNC_RESERVE, 0, 5, 7, 50, ST_OK));
        add_row(cmd_row(FUNC_FREE_ALL, 0, 0, 0, 60, ST_OK));
        add_row(cfg_row(REG_RESOURCE_COUNT, 16'd1));
        add_row(cmd_row(FUNC_RESERVE, 0, 0, 2, 70, ST_OK));
        add_row(cmd_row(FUNC_RESERVE, 0, 1, 2, 70, ST_BAD_INDEX));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].cfg_addr, dir_rows[i].cfg_data);
            else
                send_cmd(dir_rows[i].c, dir_rows[i].typed_st);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: begin cnt = 5'd16; mask = 16'hFFFF; end
                1: begin cnt = 5'($urandom_range(2, 15)); mask = 16'($urandom); end
                2: begin cnt = 5'd31; mask = 16'hFFFF; end
                3: begin cnt = 5'd1; mask = 16'hFFFF; end
                4: begin cnt = 5'd16; mask = 16'($urandom) | 16'h000F; end
                5: begin cnt = 5'($urandom); mask = 16'hFFFF; end
                6: begin cnt = 5'd16; mask = 16'h0000; end
                default: begin cnt = 5'd8; mask = 16'($urandom); end
            endcase
            write_reg(REG_RESOURCE_COUNT, {11'($urandom), cnt});
            write_reg(REG_USER_ALLOW_MASK, mask);
            // hold the response side while commands keep coming
            if (p == 2)
                long_hold_req = 1'b1;
            burst_left = 0;
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                if (p == 5 && i == RAND_PER_PHASE / 2)
                    drain_table();
                if (burst_left == 0)
                begin
                    if (p != 4)
                        idle_sender($urandom_range(1, 14));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                send_cmd(rand_cmd(), PREDICTED);
            end
        end

        drain_table();
        repeat (3 * N_RES) @(negedge clk);

        $display("summary: %0d commands, %0d responses checked, %0d of them release notices",
                 n_cmd, n_rsp, n_notice);
        $display("summary: %0d register writes over %0d random phases, %0d cycles",
                 n_cfg, N_PHASES, cycles);
        if (errors == 0)
            $display("resource_lease_table_tb: done, clean");
        else
            $display("resource_lease_table_tb: done, errors");
        $finish;
    end

endmodule
